// File: rtl/assert_macros.svh
// assertion helpers; the using module supplies clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/kwm_pkg.sv
package kwm_pkg;

  // defaults for the top level parameters
  localparam int NumListsDef  = 8;
  localparam int ListDepthDef = 128;

  // depth of the request and result queues
  localparam int ReqQDepth = 2;
  localparam int ResQDepth = 2;

  localparam int OpW  = 2;
  localparam int IdxW = 3;
  localparam int ValW = 32;
  localparam int StW  = 2;

  // op codes
  localparam logic [OpW-1:0] OP_PUSH  = 2'd0;
  localparam logic [OpW-1:0] OP_POP   = 2'd1;
  localparam logic [OpW-1:0] OP_CLEAR = 2'd2;

  // status codes
  localparam logic [StW-1:0] ST_OK    = 2'd0;
  localparam logic [StW-1:0] ST_FULL  = 2'd1;
  localparam logic [StW-1:0] ST_EMPTY = 2'd2;

  // request class decided by the front end
  typedef enum logic [2:0] {
    K_PUSH,
    K_REJECT,
    K_POP,
    K_CLEAR,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [IdxW-1:0]        idx;
    logic signed [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic [IdxW-1:0]        src;
    logic [StW-1:0]         status;
  } res_t;

endpackage

// File: rtl/kwm_front.sv
module kwm_front #(
  parameter int NUM_LISTS = kwm_pkg::NumListsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic [kwm_pkg::OpW-1:0]      in_op,
  input  logic [kwm_pkg::IdxW-1:0]     in_list_index,
  input  logic signed [kwm_pkg::ValW-1:0] in_value,
  output logic                         in_full,
  output logic                         req_valid,
  output kwm_pkg::req_t                req,
  input  logic                         req_take
);

  localparam int QD = kwm_pkg::ReqQDepth;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  kwm_pkg::req_t  q_r [QD];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  kwm_pkg::req_t  cls;
  logic           wr_en, rd_en;

  // classify the incoming request
  always_comb begin
    cls.idx   = in_list_index;
    cls.value = in_value;
    case (in_op)
      kwm_pkg::OP_PUSH: begin
        cls.kind = (int'(in_list_index) >= NUM_LISTS) ? kwm_pkg::K_REJECT : kwm_pkg::K_PUSH;
      end
      kwm_pkg::OP_POP:   cls.kind = kwm_pkg::K_POP;
      kwm_pkg::OP_CLEAR: cls.kind = kwm_pkg::K_CLEAR;
      default:           cls.kind = kwm_pkg::K_NOP;
    endcase
  end

  assign in_full   = (cnt_r == CW'(QD));
  assign req_valid = (cnt_r != '0);
  assign req       = q_r[rd_ptr_r];
  assign wr_en     = in_push && !in_full;
  assign rd_en     = req_take && req_valid;

  // request queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  // queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(wr_en) - CW'(rd_en);
    end
  end

endmodule

// File: rtl/kwm_back.sv
`include "assert_macros.svh"

module kwm_back #(
  parameter int NUM_LISTS  = kwm_pkg::NumListsDef,
  parameter int LIST_DEPTH = kwm_pkg::ListDepthDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  kwm_pkg::req_t req,
  output logic          req_take,
  output logic          res_valid,
  output kwm_pkg::res_t res,
  input  logic          res_space
);

  localparam int LW = $clog2(NUM_LISTS);
  localparam int PW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int VW = kwm_pkg::ValW;
  localparam int AW = LW + PW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REFILL
  } state_t;

  state_t          state_r;
  logic [PW-1:0]   rp_r   [NUM_LISTS];
  logic [PW-1:0]   wp_r   [NUM_LISTS];
  logic [CW-1:0]   fill_r [NUM_LISTS];
  logic [VW-1:0]   head_r [NUM_LISTS];
  logic [LW-1:0]   scan_i_r, best_r, refill_list_r;
  logic            found_r;
  logic [VW-1:0]   best_key_r;

  logic [VW-1:0]   mem [2**AW];
  logic [VW-1:0]   mem_rdata_r;

  logic [LW-1:0]   pidx;
  logic            push_ok;
  logic [VW-1:0]   cur_key;
  logic            cur_live, upd, last, fin_found;
  logic [LW-1:0]   fin_best;
  logic [PW-1:0]   fin_rp_nxt;
  logic [CW-1:0]   fin_fill_nxt;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;

  // push decode
  assign req_take = req_valid && (state_r == S_IDLE) && res_space;
  assign pidx     = LW'(req.idx);
  assign push_ok  = (fill_r[pidx] != CW'(LIST_DEPTH));

  // one list per cycle of the minimum scan, order key flips the sign bit
  assign cur_key    = head_r[scan_i_r] ^ {1'b1, {(VW-1){1'b0}}};
  assign cur_live   = (fill_r[scan_i_r] != '0);
  assign upd        = cur_live && (!found_r || (cur_key < best_key_r));
  assign last       = (scan_i_r == LW'(NUM_LISTS - 1));
  assign fin_found  = found_r || cur_live;
  assign fin_best   = upd ? scan_i_r : best_r;
  assign fin_rp_nxt = (rp_r[fin_best] == PW'(LIST_DEPTH - 1)) ? '0 : rp_r[fin_best] + 1'b1;
  assign fin_fill_nxt = fill_r[fin_best] - 1'b1;

  // memory port control
  assign mem_we    = req_take && (req.kind == kwm_pkg::K_PUSH) && push_ok;
  assign mem_waddr = {pidx, wp_r[pidx]};
  assign mem_re    = (state_r == S_SCAN) && last && fin_found && (fin_fill_nxt != '0);
  assign mem_raddr = {fin_best, fin_rp_nxt};

  // result generation
  always_comb begin
    res_valid  = 1'b0;
    res.value  = '0;
    res.src    = '0;
    res.status = kwm_pkg::ST_OK;
    if (state_r == S_SCAN && last) begin
      res_valid = 1'b1;
      if (fin_found) begin
        res.value = (upd ? head_r[scan_i_r] : head_r[best_r]);
        res.src   = kwm_pkg::IdxW'(fin_best);
      end else begin
        res.status = kwm_pkg::ST_EMPTY;
      end
    end else if (req_take && req.kind != kwm_pkg::K_POP) begin
      res_valid = 1'b1;
      case (req.kind)
        kwm_pkg::K_REJECT: res.status = kwm_pkg::ST_FULL;
        kwm_pkg::K_PUSH:   res.status = push_ok ? kwm_pkg::ST_OK : kwm_pkg::ST_FULL;
        default:           res.status = kwm_pkg::ST_OK;
      endcase
    end
  end

  // element memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= req.value;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // sequencer and list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      found_r  <= 1'b0;
      scan_i_r <= '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        rp_r[i]   <= '0;
        wp_r[i]   <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (req_take) begin
            case (req.kind)
              kwm_pkg::K_PUSH: begin
                if (push_ok) begin
                  wp_r[pidx] <= (wp_r[pidx] == PW'(LIST_DEPTH - 1)) ? '0 : wp_r[pidx] + 1'b1;
                  fill_r[pidx] <= fill_r[pidx] + 1'b1;
                  if (fill_r[pidx] == '0) begin
                    head_r[pidx] <= req.value;
                  end
                end
              end
              kwm_pkg::K_POP: begin
                state_r  <= S_SCAN;
                scan_i_r <= '0;
                found_r  <= 1'b0;
              end
              kwm_pkg::K_CLEAR: begin
                for (int i = 0; i < NUM_LISTS; i++) begin
                  rp_r[i]   <= '0;
                  wp_r[i]   <= '0;
                  fill_r[i] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (upd) begin
            found_r    <= 1'b1;
            best_r     <= scan_i_r;
            best_key_r <= cur_key;
          end
          scan_i_r <= scan_i_r + 1'b1;
          if (last) begin
            state_r <= S_IDLE;
            if (fin_found) begin
              rp_r[fin_best]   <= fin_rp_nxt;
              fill_r[fin_best] <= fin_fill_nxt;
            end
            if (mem_re) begin
              state_r       <= S_REFILL;
              refill_list_r <= fin_best;
            end
          end
        end
        S_REFILL: begin
          head_r[refill_list_r] <= mem_rdata_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_res_space, res_valid && state_r == S_SCAN, res_space, "result queue overrun")
  `ASSERT_NXT(a_refill_follows, mem_re, state_r == S_REFILL, "refill not scheduled")
  `ASSERT_IMP(a_take_idle, req_take, state_r == S_IDLE && !mem_re, "request taken while busy")

endmodule

// File: rtl/kwm_resq.sv
module kwm_resq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_valid,
  input  kwm_pkg::res_t                   wr_data,
  output logic                            wr_space,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic signed [kwm_pkg::ValW-1:0] out_value_out,
  output logic [kwm_pkg::IdxW-1:0]        out_source_list,
  output logic [kwm_pkg::StW-1:0]         out_status
);

  localparam int QD = kwm_pkg::ResQDepth;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  kwm_pkg::res_t q_r [QD];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          wr_en, rd_en;

  assign wr_space        = (cnt_r != CW'(QD));
  assign out_empty       = (cnt_r == '0);
  assign wr_en           = wr_valid && wr_space;
  assign rd_en           = out_pop && !out_empty;
  assign out_value_out   = q_r[rd_ptr_r].value;
  assign out_source_list = q_r[rd_ptr_r].src;
  assign out_status      = q_r[rd_ptr_r].status;

  // result storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(wr_en) - CW'(rd_en);
    end
  end

endmodule

// File: rtl/k_way_sorted_merge_unit.sv
// K-way merge of ascending lists: a push appends a value to one of NUM_LISTS lists of
// LIST_DEPTH entries, a pop removes the smallest head (ties to the lowest list), a clear
// empties all lists. Requests enter a two-entry queue and results leave through a
// two-entry queue, one result per request. Push, clear and unused codes complete in the
// execution engine as they are taken; a pop scans the lists, comparing one cached head
// per cycle, and when the list keeps entries it then refills that head through a
// registered read of the element memory.
module k_way_sorted_merge_unit #(
  parameter int NUM_LISTS  = kwm_pkg::NumListsDef,
  parameter int LIST_DEPTH = kwm_pkg::ListDepthDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [kwm_pkg::OpW-1:0]         in_op,
  input  logic [kwm_pkg::IdxW-1:0]        in_list_index,
  input  logic signed [kwm_pkg::ValW-1:0] in_value,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [kwm_pkg::ValW-1:0] out_value_out,
  output logic [kwm_pkg::IdxW-1:0]        out_source_list,
  output logic [kwm_pkg::StW-1:0]         out_status
);

  logic          req_valid, req_take, res_valid, res_space;
  kwm_pkg::req_t req;
  kwm_pkg::res_t res;

  // request intake and classification
  kwm_front #(.NUM_LISTS(NUM_LISTS)) u_front (
    .clk, .rst_n,
    .in_push(push), .in_op, .in_list_index, .in_value, .in_full(full),
    .req_valid, .req, .req_take
  );

  // list storage and merge engine
  kwm_back #(.NUM_LISTS(NUM_LISTS), .LIST_DEPTH(LIST_DEPTH)) u_back (
    .clk, .rst_n,
    .req_valid, .req, .req_take,
    .res_valid, .res, .res_space
  );

  // result queue
  kwm_resq u_resq (
    .clk, .rst_n,
    .wr_valid(res_valid), .wr_data(res), .wr_space(res_space),
    .out_empty(empty), .out_pop(pop),
    .out_value_out, .out_source_list, .out_status
  );

endmodule
